// ----- rtl/wfr_pkg.sv -----
// wfr_pkg: shared types, constants and helpers for the WebSocket frame receiver.
// No dependencies; imported by every module of the block.
`default_nettype none

package wfr_pkg;

  // Width of the payload length counter; the wire format carries at most 64 bits.
  localparam int unsigned LenBits  = 64;
  // Command queue between the parser and the beat emitter.
  localparam int unsigned CmdDepth = 4;
  localparam int unsigned CmdPtrW  = $clog2(CmdDepth);
  localparam int unsigned CmdCntW  = $clog2(CmdDepth + 1);
  // Pong header: 0x8A, length byte, four mask key bytes.
  localparam int unsigned HdrBeats = 6;
  localparam int unsigned HdrCntW  = $clog2(HdrBeats);

  localparam logic [31:0] PongKeyReset = 32'h1234_5678;

  localparam logic [3:0] OpText  = 4'h1;
  localparam logic [3:0] OpClose = 4'h8;
  localparam logic [3:0] OpPing  = 4'h9;

  localparam logic [6:0] Len16   = 7'd126;
  localparam logic [6:0] Len64   = 7'd127;
  localparam logic [6:0] PongMax = 7'd125;
  localparam logic [7:0] PongHdr0 = 8'h8A;
  localparam logic [7:0] MaskBit  = 8'h80;

  localparam logic [3:0] ExtBytes16 = 4'd2;
  localparam logic [3:0] ExtBytes64 = 4'd8;
  localparam logic [3:0] KeyBytes   = 4'd4;

  // Output channel codes
  localparam logic [1:0] ChText  = 2'd0;
  localparam logic [1:0] ChPong  = 2'd1;
  localparam logic [1:0] ChClose = 2'd2;

  // Parser phase, one-hot
  typedef enum logic [4:0] {
    PH_HDR0 = 5'b00001,
    PH_HDR1 = 5'b00010,
    PH_EXT  = 5'b00100,
    PH_KEY  = 5'b01000,
    PH_PAY  = 5'b10000
  } phase_e;

  typedef enum logic [2:0] {
    CMD_TEXT,      // text payload byte
    CMD_EMPTY,     // empty text message
    CMD_PONG_HDR,  // six-beat pong header; data holds the length
    CMD_PONG,      // pong payload byte, already masked
    CMD_CLOSE      // close event
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e   kind;
    logic [7:0]  data;
    logic        last;
  } cmd_t;

  // Mask key byte for a payload position; position 0 is the top byte.
  function automatic logic [7:0] key_byte(input logic [31:0] key, input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0:    b = key[31:24];
      2'd1:    b = key[23:16];
      2'd2:    b = key[15:8];
      default: b = key[7:0];
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/websocket_frame_receiver_top.sv -----
// websocket_frame_receiver_top: WebSocket (RFC 6455) frame receiver, top level.
// Depends on wfr_pkg, wfr_front, wfr_cmd_fifo and wfr_back.
`default_nettype none

// Received stream bytes enter on the slave side, one byte per beat, and are
// parsed as WebSocket frames. Unfragmented text frames come out as unmasked
// bytes on channel 0 with tlast on the final byte (an empty text frame gives
// a single beat with has_data clear). A ping of up to 125 bytes is answered
// on channel 1 with a pong frame masked by the pong mask key register; a
// close frame gives one channel 2 event, after which input bytes are taken
// and discarded until reset. Throughput is one input byte per cycle: the
// parser takes a byte every cycle while the four-entry command queue has
// room. A pong reply header costs six output beats for one command, so a
// ping header back-pressures input only once the queue fills. An accepted
// byte is queued, then loaded into the output register. The mask key
// register must only be written while the block is idle.
module websocket_frame_receiver_top
  import wfr_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // received stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  // results
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata,   // [7:0] data_byte
  output logic [2:0]       m_axis_tuser,   // [1:0] channel, [2] has_data
  output logic             m_axis_tlast,   // last
  // pong mask key register
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [31:0] cfg_data_i
);

  logic [31:0] pong_key_q;
  logic        push;
  cmd_t        push_cmd;
  logic        q_full;
  logic        q_empty;
  logic        pop;
  cmd_t        head;
  logic [1:0]  out_ch;
  logic        out_has;

  // Key register: always writable, first mask byte in the top bits
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pong_key_q <= PongKeyReset;
    end else if (cfg_valid_i) begin
      pong_key_q <= cfg_data_i;
    end
  end

  wfr_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_byte_i  (s_axis_tdata),
    .pong_key_i (pong_key_q),
    .q_full_i   (q_full),
    .push_o     (push),
    .push_cmd_o (push_cmd)
  );

  wfr_cmd_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .full_o     (q_full),
    .pop_i      (pop),
    .empty_o    (q_empty),
    .head_o     (head)
  );

  wfr_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_empty_i     (q_empty),
    .head_i        (head),
    .pop_o         (pop),
    .pong_key_i    (pong_key_q),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_channel_o (out_ch),
    .out_data_o    (m_axis_tdata),
    .out_has_o     (out_has),
    .out_last_o    (m_axis_tlast)
  );

  assign m_axis_tuser = {out_has, out_ch};

endmodule

`default_nettype wire

// ----- rtl/wfr_front.sv -----
// wfr_front: byte-wide frame header parser and payload unmasker.
// Depends on wfr_pkg; pushes at most one command per accepted byte.
`default_nettype none

module wfr_front
  import wfr_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  in_byte_i,
  input  wire logic [31:0] pong_key_i,
  input  wire logic        q_full_i,
  output logic             push_o,
  output cmd_t             push_cmd_o
);

  phase_e              phase_q, phase_d;
  logic [3:0]          opcode_q, opcode_d;
  logic                final_q, final_d;
  logic                masked_q, masked_d;
  logic [LenBits-1:0]  rem_q, rem_d;
  logic [3:0]          cnt_q, cnt_d;
  logic [31:0]         rx_key_q, rx_key_d;
  logic [1:0]          idx_q, idx_d;
  logic                pong_q, pong_d;
  logic                closed_q, closed_d;

  logic                accept;
  logic [LenBits-1:0]  len_new;
  logic                hdr_done;
  logic                len_done;
  logic                fin_empty;
  logic                fin_pong;
  logic                is_last;
  logic [7:0]          pay;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    phase_d    = phase_q;
    opcode_d   = opcode_q;
    final_d    = final_q;
    masked_d   = masked_q;
    rem_d      = rem_q;
    cnt_d      = cnt_q;
    rx_key_d   = rx_key_q;
    idx_d      = idx_q;
    pong_d     = pong_q;
    closed_d   = closed_q;
    push_o     = 1'b0;
    push_cmd_o = '{kind: CMD_TEXT, data: 8'h00, last: 1'b0};
    len_new    = rem_q;
    hdr_done   = 1'b0;
    len_done   = 1'b0;
    is_last    = (rem_q == LenBits'(1));
    pay        = in_byte_i ^ (masked_q ? key_byte(rx_key_q, idx_q) : 8'h00);

    if (accept && !closed_q) begin
      unique case (phase_q)
        PH_HDR0: begin
          opcode_d = in_byte_i[3:0];
          final_d  = in_byte_i[7];
          phase_d  = PH_HDR1;
        end
        PH_HDR1: begin
          masked_d = in_byte_i[7];
          if (in_byte_i[6:0] == Len16 || in_byte_i[6:0] == Len64) begin
            rem_d   = '0;
            cnt_d   = (in_byte_i[6:0] == Len16) ? ExtBytes16 : ExtBytes64;
            phase_d = PH_EXT;
          end else begin
            len_new  = LenBits'(in_byte_i[6:0]);
            rem_d    = len_new;
            len_done = 1'b1;
          end
        end
        PH_EXT: begin
          len_new = {rem_q[LenBits-9:0], in_byte_i};
          rem_d   = len_new;
          cnt_d   = cnt_q - 4'd1;
          if (cnt_q == 4'd1) begin
            len_done = 1'b1;
          end
        end
        PH_KEY: begin
          rx_key_d = {rx_key_q[23:0], in_byte_i};
          cnt_d    = cnt_q - 4'd1;
          if (cnt_q == 4'd1) begin
            hdr_done = 1'b1;
          end
        end
        PH_PAY: begin
          if (opcode_q == OpText && final_q) begin
            push_o     = 1'b1;
            push_cmd_o = '{kind: CMD_TEXT, data: pay, last: is_last};
          end else if (pong_q) begin
            push_o     = 1'b1;
            push_cmd_o = '{kind: CMD_PONG, data: pay ^ key_byte(pong_key_i, idx_q),
                           last: is_last};
          end else if (opcode_q == OpClose && is_last) begin
            push_o     = 1'b1;
            push_cmd_o = '{kind: CMD_CLOSE, data: 8'h00, last: 1'b0};
            closed_d   = 1'b1;
          end
          idx_d = idx_q + 2'd1;
          rem_d = rem_q - LenBits'(1);
          if (is_last) begin
            phase_d = PH_HDR0;
          end
        end
        default: phase_d = PH_HDR0;
      endcase

      // length known: either collect the mask key or close the header
      if (len_done) begin
        if (masked_d) begin
          cnt_d    = KeyBytes;
          rx_key_d = '0;
          phase_d  = PH_KEY;
        end else begin
          hdr_done = 1'b1;
        end
      end

      if (hdr_done) begin
        fin_empty = (rem_d == '0);
        fin_pong  = (opcode_q == OpPing) && (rem_d <= LenBits'(PongMax));
        pong_d    = fin_pong;
        if (fin_pong) begin
          push_o     = 1'b1;
          push_cmd_o = '{kind: CMD_PONG_HDR, data: {1'b0, rem_d[6:0]}, last: fin_empty};
        end else if (fin_empty && opcode_q == OpText && final_q) begin
          push_o     = 1'b1;
          push_cmd_o = '{kind: CMD_EMPTY, data: 8'h00, last: 1'b1};
        end else if (fin_empty && opcode_q == OpClose) begin
          push_o     = 1'b1;
          push_cmd_o = '{kind: CMD_CLOSE, data: 8'h00, last: 1'b0};
          closed_d   = 1'b1;
        end
        if (fin_empty) begin
          phase_d = PH_HDR0;
        end else begin
          idx_d   = 2'd0;
          phase_d = PH_PAY;
        end
      end else begin
        fin_empty = 1'b0;
        fin_pong  = 1'b0;
      end
    end else begin
      fin_empty = 1'b0;
      fin_pong  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HDR0;
      opcode_q <= '0;
      final_q  <= 1'b0;
      masked_q <= 1'b0;
      rem_q    <= '0;
      cnt_q    <= '0;
      rx_key_q <= '0;
      idx_q    <= '0;
      pong_q   <= 1'b0;
      closed_q <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      opcode_q <= opcode_d;
      final_q  <= final_d;
      masked_q <= masked_d;
      rem_q    <= rem_d;
      cnt_q    <= cnt_d;
      rx_key_q <= rx_key_d;
      idx_q    <= idx_d;
      pong_q   <= pong_d;
      closed_q <= closed_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/wfr_cmd_fifo.sv -----
// wfr_cmd_fifo: small register queue of parser commands.
// Depends on wfr_pkg; head entry is visible without a pop.
`default_nettype none

module wfr_cmd_fifo
  import wfr_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire cmd_t push_cmd_i,
  output logic      full_o,
  input  wire logic pop_i,
  output logic      empty_o,
  output cmd_t      head_o
);

  cmd_t                mem_q [CmdDepth];
  logic [CmdPtrW-1:0]  wr_q, wr_d;
  logic [CmdPtrW-1:0]  rd_q, rd_d;
  logic [CmdCntW-1:0]  cnt_q, cnt_d;
  logic                do_push;
  logic                do_pop;

  assign full_o  = (cnt_q == CmdCntW'(CmdDepth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_d  = do_push ? wr_q + CmdPtrW'(1) : wr_q;
    rd_d  = do_pop ? rd_q + CmdPtrW'(1) : rd_q;
    cnt_d = cnt_q + CmdCntW'(do_push) - CmdCntW'(do_pop);
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/wfr_back.sv -----
// wfr_back: expands queued commands into result beats held in an output register.
// Depends on wfr_pkg; the pong header command becomes six beats.
`default_nettype none

module wfr_back
  import wfr_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        q_empty_i,
  input  wire cmd_t        head_i,
  output logic             pop_o,
  input  wire logic [31:0] pong_key_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [1:0]       out_channel_o,
  output logic [7:0]       out_data_o,
  output logic             out_has_o,
  output logic             out_last_o
);

  logic               valid_q, valid_d;
  logic [1:0]         ch_q, ch_d;
  logic [7:0]         data_q, data_d;
  logic               has_q, has_d;
  logic               last_q, last_d;
  logic [HdrCntW-1:0] hcnt_q, hcnt_d;
  logic               load;
  logic [1:0]         key_sel;

  assign load    = !valid_q || out_ready_i;
  assign key_sel = hcnt_q[1:0] - 2'd2;

  always_comb begin
    valid_d = valid_q;
    ch_d    = ch_q;
    data_d  = data_q;
    has_d   = has_q;
    last_d  = last_q;
    hcnt_d  = hcnt_q;
    pop_o   = 1'b0;
    if (load) begin
      valid_d = !q_empty_i;
      if (!q_empty_i) begin
        pop_o  = 1'b1;
        last_d = head_i.last;
        unique case (head_i.kind)
          CMD_TEXT: begin
            ch_d = ChText;  data_d = head_i.data; has_d = 1'b1;
          end
          CMD_EMPTY: begin
            ch_d = ChText;  data_d = 8'h00;       has_d = 1'b0;
          end
          CMD_PONG: begin
            ch_d = ChPong;  data_d = head_i.data; has_d = 1'b1;
          end
          CMD_CLOSE: begin
            ch_d = ChClose; data_d = 8'h00;       has_d = 1'b0; last_d = 1'b0;
          end
          CMD_PONG_HDR: begin
            ch_d  = ChPong;
            has_d = 1'b1;
            if (hcnt_q == HdrCntW'(0)) begin
              data_d = PongHdr0;
            end else if (hcnt_q == HdrCntW'(1)) begin
              data_d = MaskBit | head_i.data;
            end else begin
              data_d = key_byte(pong_key_i, key_sel);
            end
            if (hcnt_q == HdrCntW'(HdrBeats - 1)) begin
              hcnt_d = '0;
            end else begin
              pop_o  = 1'b0;
              last_d = 1'b0;
              hcnt_d = hcnt_q + HdrCntW'(1);
            end
          end
          default: begin
            ch_d = ChText;  data_d = 8'h00;       has_d = 1'b0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      hcnt_q  <= '0;
    end else begin
      valid_q <= valid_d;
      hcnt_q  <= hcnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ch_q   <= ch_d;
    data_q <= data_d;
    has_q  <= has_d;
    last_q <= last_d;
  end

  assign out_valid_o   = valid_q;
  assign out_channel_o = ch_q;
  assign out_data_o    = data_q;
  assign out_has_o     = has_q;
  assign out_last_o    = last_q;

endmodule

`default_nettype wire
